>>> rtl/core/pifu_pkg.sv
`timescale 1ns / 1ps

package pifu_pkg;

	// One byte of the incoming Ethernet frame.
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} frame_t;

	// One filter decision.
	typedef struct packed {
		logic       drop;
		logic [2:0] reason;
	} verdict_t;

	// Header fields of one finished frame, handed from the parser to the decision stage.
	// pos is the position of the final byte, so the frame length is pos + 1.
	typedef struct packed {
		logic [6:0]  pos;
		logic [15:0] ether_type;
		logic [3:0]  ihl;
		logic [12:0] frag_offset;
		logic [7:0]  protocol;
		logic [31:0] dest_addr;
		logic [15:0] l4_port;
	} parse_rec_t;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] mask;
	} subnet_t;

	typedef struct packed {
		subnet_t [2:0] subnet;
		logic [15:0]   exempt_port;
	} cfg_t;

	// Configuration register indexes.
	localparam logic [2:0] CFG_FIRST_BASE   = 3'd0;
	localparam logic [2:0] CFG_FIRST_MASK   = 3'd1;
	localparam logic [2:0] CFG_SECOND_BASE  = 3'd2;
	localparam logic [2:0] CFG_SECOND_MASK  = 3'd3;
	localparam logic [2:0] CFG_THIRD_BASE   = 3'd4;
	localparam logic [2:0] CFG_THIRD_MASK   = 3'd5;
	localparam logic [2:0] CFG_EXEMPT_PORT  = 3'd6;

	// Register reset values (RFC 1918 ranges and the SSH port).
	localparam logic [31:0] RST_FIRST_BASE  = 32'h0A00_0000;
	localparam logic [31:0] RST_FIRST_MASK  = 32'hFF00_0000;
	localparam logic [31:0] RST_SECOND_BASE = 32'hAC10_0000;
	localparam logic [31:0] RST_SECOND_MASK = 32'hFFF0_0000;
	localparam logic [31:0] RST_THIRD_BASE  = 32'hC0A8_0000;
	localparam logic [31:0] RST_THIRD_MASK  = 32'hFFFF_0000;
	localparam logic [15:0] RST_EXEMPT_PORT = 16'd22;

	// Reason codes.
	localparam logic [2:0] REASON_SHORT   = 3'd0;
	localparam logic [2:0] REASON_BAD_HDR = 3'd1;
	localparam logic [2:0] REASON_PUBLIC  = 3'd2;
	localparam logic [2:0] REASON_EXEMPT  = 3'd3;
	localparam logic [2:0] REASON_ICMP    = 3'd4;
	localparam logic [2:0] REASON_PRIVATE = 3'd5;

	// Frame layout.
	localparam logic [6:0]  POS_ETYPE_HI  = 7'd12;
	localparam logic [6:0]  POS_ETYPE_LO  = 7'd13;
	localparam logic [6:0]  POS_IHL       = 7'd14;
	localparam logic [6:0]  POS_FRAG_HI   = 7'd20;
	localparam logic [6:0]  POS_FRAG_LO   = 7'd21;
	localparam logic [6:0]  POS_PROTO     = 7'd23;
	localparam logic [6:0]  POS_DEST_FST  = 7'd30;
	localparam logic [6:0]  POS_DEST_LST  = 7'd33;
	localparam logic [6:0]  POS_MAX       = 7'd127;
	localparam logic [6:0]  ETH_HDR_LEN   = 7'd14;
	localparam logic [3:0]  MIN_IHL       = 4'd5;
	localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP    = 8'd1;
	localparam logic [7:0]  PROTO_TCP     = 8'd6;

endpackage

>>> rtl/core/pifu_parse.sv
`timescale 1ns / 1ps

// Front end: counts frame bytes and captures header fields at their positions.
module pifu_parse
	import pifu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  frame_t     frame,
	output logic       push,
	output parse_rec_t rec
);

	logic [6:0]  pos_q;
	logic [15:0] ether_type_q;
	logic [3:0]  ihl_q;
	logic [12:0] frag_q;
	logic [7:0]  proto_q;
	logic [31:0] dest_q;
	logic [15:0] sport_q;

	logic [15:0] ether_type_nxt;
	logic [3:0]  ihl_nxt;
	logic [12:0] frag_nxt;
	logic [7:0]  proto_nxt;
	logic [31:0] dest_nxt;
	logic [15:0] sport_nxt;
	logic [6:0]  l4_pos;
	logic [7:0]  b;

	assign b      = frame.frame_byte;
	assign l4_pos = ETH_HDR_LEN + {1'b0, ihl_q, 2'b00};

	always_comb begin
		ether_type_nxt = ether_type_q;
		ihl_nxt        = ihl_q;
		frag_nxt       = frag_q;
		proto_nxt      = proto_q;
		dest_nxt       = dest_q;
		sport_nxt      = sport_q;
		priority if (pos_q == POS_ETYPE_HI) begin
			ether_type_nxt = {b, ether_type_q[7:0]};
		end else if (pos_q == POS_ETYPE_LO) begin
			ether_type_nxt = {ether_type_q[15:8], b};
		end else if (pos_q == POS_IHL) begin
			ihl_nxt = b[3:0];
		end else if (pos_q == POS_FRAG_HI) begin
			frag_nxt = {b[4:0], frag_q[7:0]};
		end else if (pos_q == POS_FRAG_LO) begin
			frag_nxt = {frag_q[12:8], b};
		end else if (pos_q == POS_PROTO) begin
			proto_nxt = b;
		end else if (pos_q >= POS_DEST_FST && pos_q <= POS_DEST_LST) begin
			dest_nxt = {dest_q[23:0], b};
		end else begin
		end
		// The L4 header starts at 34 or later, past every fixed field above.
		if (ihl_q >= MIN_IHL) begin
			if (pos_q == l4_pos) begin
				sport_nxt = {b, sport_q[7:0]};
			end else if (pos_q == l4_pos + 7'd1) begin
				sport_nxt = {sport_q[15:8], b};
			end
		end
	end

	assign push            = accept && frame.frame_end;
	assign rec.pos         = pos_q;
	assign rec.ether_type  = ether_type_nxt;
	assign rec.ihl         = ihl_nxt;
	assign rec.frag_offset = frag_nxt;
	assign rec.protocol    = proto_nxt;
	assign rec.dest_addr   = dest_nxt;
	assign rec.l4_port     = sport_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			ether_type_q <= '0;
			ihl_q        <= '0;
			frag_q       <= '0;
			proto_q      <= '0;
			dest_q       <= '0;
			sport_q      <= '0;
		end else if (accept) begin
			if (frame.frame_end) begin
				pos_q        <= '0;
				ether_type_q <= '0;
				ihl_q        <= '0;
				frag_q       <= '0;
				proto_q      <= '0;
				dest_q       <= '0;
				sport_q      <= '0;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 7'd1;
				end
				ether_type_q <= ether_type_nxt;
				ihl_q        <= ihl_nxt;
				frag_q       <= frag_nxt;
				proto_q      <= proto_nxt;
				dest_q       <= dest_nxt;
				sport_q      <= sport_nxt;
			end
		end
	end

endmodule

>>> rtl/core/pifu_queue.sv
`timescale 1ns / 1ps

// Small register queue of parsed frame records.
module pifu_queue
	import pifu_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  parse_rec_t push_rec,
	input  logic       pop,
	output parse_rec_t pop_rec,
	output logic       full,
	output logic       empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	parse_rec_t          store_q [DEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [PW-1:0]       rd_ptr_q;
	logic [CW-1:0]       count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_rec = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/core/pifu_verdict.sv
`timescale 1ns / 1ps

// Back end: turns one parsed record into a pass or drop decision and holds it
// in the output register until it is taken.
module pifu_verdict
	import pifu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       rec_valid,
	input  parse_rec_t rec,
	output logic       pop,
	output logic       verdict_valid,
	input  logic       verdict_stall,
	output verdict_t   verdict
);

	logic       valid_q;
	verdict_t   verdict_q;
	verdict_t   result;
	logic [2:0] hit;
	logic [6:0] tcp_min_pos;

	// The last byte must reach position 17 + 4*IHL for four L4 bytes to be present.
	assign tcp_min_pos = 7'd17 + {1'b0, rec.ihl, 2'b00};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hit[i] = (rec.dest_addr & cfg.subnet[i].mask)
				== (cfg.subnet[i].base & cfg.subnet[i].mask);
		end
	end

	always_comb begin
		result.drop   = 1'b0;
		result.reason = REASON_SHORT;
		// Length below 34 bytes means the last byte sits before position 33.
		priority if (rec.ether_type != ETYPE_IPV4 || rec.pos < 7'd33) begin
			result.reason = REASON_SHORT;
		end else if (rec.ihl < MIN_IHL || rec.frag_offset != '0) begin
			result.reason = REASON_BAD_HDR;
		end else if (hit == '0) begin
			result.reason = REASON_PUBLIC;
		end else if (rec.protocol == PROTO_ICMP) begin
			result.drop   = 1'b1;
			result.reason = REASON_ICMP;
		end else if (rec.protocol == PROTO_TCP && rec.pos < tcp_min_pos) begin
			result.reason = REASON_SHORT;
		end else if (rec.protocol == PROTO_TCP && rec.l4_port == cfg.exempt_port) begin
			result.reason = REASON_EXEMPT;
		end else begin
			result.drop   = 1'b1;
			result.reason = REASON_PRIVATE;
		end
	end

	assign pop           = rec_valid && (!valid_q || !verdict_stall);
	assign verdict_valid = valid_q;
	assign verdict       = verdict_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!verdict_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			verdict_q <= result;
		end
	end

endmodule

>>> rtl/core/private_ipv4_packet_filter_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// frame     in         frame_valid / frame_stall  frame_t   (frame_byte, frame_end)
// verdict   out        verdict_valid / verdict_stall  verdict_t (drop, reason)
// cfg       in         cfg_valid / cfg_ready      cfg_index (3 bits), cfg_data (32 bits)
//
// The block takes one frame byte per clock while frame_stall is low. A frame's
// record is queued with its final byte; its verdict is registered when the record
// is popped. Reset clears the byte counter, the captured fields, the queue and the
// output valid, and loads the register defaults. frame_stall rises only when the
// record queue is full, which needs QUEUE_DEPTH frame ends waiting behind a stalled
// verdict channel; cfg_ready is always high.
module private_ipv4_packet_filter_unit
	import pifu_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        frame_valid,
	output logic        frame_stall,
	input  frame_t      frame,
	output logic        verdict_valid,
	input  logic        verdict_stall,
	output verdict_t    verdict,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t       cfg_q;
	logic       frame_accept;
	logic       rec_push;
	parse_rec_t rec_in;
	parse_rec_t rec_out;
	logic       rec_pop;
	logic       queue_full;
	logic       queue_empty;

	// Configuration writes land directly in the register file. Indexes past the
	// exempt port have no register behind them and are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.subnet[0].base <= RST_FIRST_BASE;
			cfg_q.subnet[0].mask <= RST_FIRST_MASK;
			cfg_q.subnet[1].base <= RST_SECOND_BASE;
			cfg_q.subnet[1].mask <= RST_SECOND_MASK;
			cfg_q.subnet[2].base <= RST_THIRD_BASE;
			cfg_q.subnet[2].mask <= RST_THIRD_MASK;
			cfg_q.exempt_port    <= RST_EXEMPT_PORT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FIRST_BASE:  cfg_q.subnet[0].base <= cfg_data;
				CFG_FIRST_MASK:  cfg_q.subnet[0].mask <= cfg_data;
				CFG_SECOND_BASE: cfg_q.subnet[1].base <= cfg_data;
				CFG_SECOND_MASK: cfg_q.subnet[1].mask <= cfg_data;
				CFG_THIRD_BASE:  cfg_q.subnet[2].base <= cfg_data;
				CFG_THIRD_MASK:  cfg_q.subnet[2].mask <= cfg_data;
				CFG_EXEMPT_PORT: cfg_q.exempt_port    <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// The front end never waits on the verdict channel directly; only a full
	// queue holds off new bytes.
	assign frame_stall  = queue_full;
	assign frame_accept = frame_valid && !frame_stall;

	pifu_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (frame_accept),
		.frame  (frame),
		.push   (rec_push),
		.rec    (rec_in)
	);

	pifu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rec_push),
		.push_rec (rec_in),
		.pop      (rec_pop),
		.pop_rec  (rec_out),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	pifu_verdict u_verdict (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.rec_valid     (!queue_empty),
		.rec           (rec_out),
		.pop           (rec_pop),
		.verdict_valid (verdict_valid),
		.verdict_stall (verdict_stall),
		.verdict       (verdict)
	);

endmodule

>>> rtl/core/pifu_checker.sv
`timescale 1ns / 1ps

module pifu_checker
	import pifu_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     frame_stall,
	input logic     verdict_valid,
	input logic     verdict_stall,
	input verdict_t verdict
);

	// A verdict that is not taken stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && verdict_stall |=> verdict_valid)
		else $error("verdict transaction withdrawn while stalled");

	// Drop is set exactly for the ICMP and private-destination reasons.
	a_drop_reason: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> (verdict.drop ==
			(verdict.reason == REASON_ICMP || verdict.reason == REASON_PRIVATE)))
		else $error("drop flag disagrees with reason");

	// Only the six defined reason codes appear.
	a_reason_range: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid |-> (verdict.reason <= REASON_PRIVATE))
		else $error("undefined reason code");

	// The input side can only be held off while the output side is backed up.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		frame_stall |-> verdict_valid)
		else $error("frame stalled with an empty output register");

endmodule

bind private_ipv4_packet_filter_unit pifu_checker u_pifu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.frame_stall   (frame_stall),
	.verdict_valid (verdict_valid),
	.verdict_stall (verdict_stall),
	.verdict       (verdict)
);

>>> verif/tb_private_ipv4_packet_filter_unit.sv
`timescale 1ns / 1ps

module tb_private_ipv4_packet_filter_unit;
	import pifu_pkg::*;

	// The run is stopped by this many clocks, far above the slowest correct run:
	// about 2000 frame bytes that each may wait out sender gaps and a verdict stall.
	localparam int CYCLE_LIMIT = 500000;
	// The register index past the last register; writes there must be ignored.
	localparam logic [2:0] CFG_SPARE = 3'd7;
	// Bytes of a minimal IPv4 header, so a frame needs 14 + 20 bytes to be judged.
	localparam int MIN_IP_LEN = 20;
	// Cycles to let pass after the last verdict before touching the registers; the
	// end of the run waits twice as long.
	localparam int SETTLE_CYCLES = 4;
	// Marks a frame description whose filler bytes are random.
	localparam logic [8:0] FILL_RANDOM = 9'h100;

	typedef enum logic [1:0] {STALL_NONE, STALL_SPARSE, STALL_RUNS} stall_mode_t;

	// One frame to send: its length, the header fields laid at their positions, the
	// byte for every other position, and, for directed frames, a verdict typed in.
	typedef struct packed {
		logic [7:0]  len;
		logic [15:0] etype;
		logic [7:0]  ver_ihl;
		logic [15:0] frag;
		logic [7:0]  proto;
		logic [31:0] dest;
		logic [15:0] sport;
		logic [8:0]  fill;
		logic        pinned;
		verdict_t    want;
	} frame_desc_t;

	logic        clk;
	logic        arst_n;
	logic        frame_valid;
	logic        frame_stall;
	frame_t      frame;
	logic        verdict_valid;
	logic        verdict_stall;
	verdict_t    verdict;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	private_ipv4_packet_filter_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame_valid   (frame_valid),
		.frame_stall   (frame_stall),
		.frame         (frame),
		.verdict_valid (verdict_valid),
		.verdict_stall (verdict_stall),
		.verdict       (verdict),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// The filter's registers as the testbench believes them to be. They follow
	// every write transaction seen on the configuration port.
	logic [31:0] net_base [3] = '{RST_FIRST_BASE, RST_SECOND_BASE, RST_THIRD_BASE};
	logic [31:0] net_mask [3] = '{RST_FIRST_MASK, RST_SECOND_MASK, RST_THIRD_MASK};
	logic [15:0] exempt_port = RST_EXEMPT_PORT;

	// Header fields gathered so far from the current frame, and the position of
	// the next byte. All of them are cleared after each frame's final byte.
	logic [6:0]  at_pos      = '0;
	logic [15:0] seen_etype  = '0;
	logic [3:0]  seen_ihl    = '0;
	logic [12:0] seen_frag   = '0;
	logic [7:0]  seen_proto  = '0;
	logic [31:0] seen_dest   = '0;
	logic [15:0] seen_sport  = '0;

	// Verdicts still owed by the block, oldest first.
	verdict_t    pending_verdicts [$];

	// A directed frame may carry a verdict typed in by hand; the driver raises
	// pin_on for the whole of such a frame, and the monitor then queues pin_verdict
	// in place of the computed one.
	logic        pin_on = 1'b0;
	verdict_t    pin_verdict = '0;

	int          cycle = 0;
	int          mismatches = 0;
	int          bytes_sent = 0;
	int          frames_sent = 0;
	int          burst_left = 0;
	logic        sender_gaps = 1'b1;
	stall_mode_t stall_mode = STALL_SPARSE;
	int          stall_run = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Prints one line for a mismatch and counts it.
	task automatic flag_mismatch(input string what, input int want, input int got);
		mismatches++;
		$display("mismatch at cycle %0d: %s: expected %0d, got %0d", cycle, what, want, got);
	endtask

	// Decides one finished frame of len bytes from the gathered header fields.
	function automatic verdict_t judge_frame(input int len);
		verdict_t v;
		logic     hit;
		int       l4;
		v.drop = 1'b0;
		v.reason = REASON_SHORT;
		hit = 1'b0;
		for (int k = 0; k < 3; k++)
			if ((seen_dest & net_mask[k]) == (net_base[k] & net_mask[k]))
				hit = 1'b1;
		// A frame too short to hold an IPv4 header, or of another ethertype, passes.
		if (len < int'(ETH_HDR_LEN) + MIN_IP_LEN || seen_etype != ETYPE_IPV4)
			return v;
		// A header length below five words or any later fragment passes untouched.
		if (seen_ihl < MIN_IHL || seen_frag != '0) begin
			v.reason = REASON_BAD_HDR;
			return v;
		end
		if (!hit) begin
			v.reason = REASON_PUBLIC;
			return v;
		end
		if (seen_proto == PROTO_ICMP) begin
			v.drop = 1'b1;
			v.reason = REASON_ICMP;
			return v;
		end
		if (seen_proto == PROTO_TCP) begin
			// TCP that ends before four bytes of its header cannot be judged: it passes.
			l4 = int'(ETH_HDR_LEN) + 4 * int'(seen_ihl);
			if (len < l4 + 4)
				return v;
			if (seen_sport == exempt_port) begin
				v.reason = REASON_EXEMPT;
				return v;
			end
		end
		v.drop = 1'b1;
		v.reason = REASON_PRIVATE;
		return v;
	endfunction

	// Takes one accepted frame byte into the gathered fields. On the final byte it
	// gives the verdict and starts over for the next frame.
	function automatic void filter_byte(input frame_t item, output logic last,
			output verdict_t v);
		int at;
		int l4;
		at = int'(at_pos);
		if (at == POS_ETYPE_HI)
			seen_etype[15:8] = item.frame_byte;
		else if (at == POS_ETYPE_LO)
			seen_etype[7:0] = item.frame_byte;
		else if (at == POS_IHL)
			seen_ihl = item.frame_byte[3:0];
		else if (at == POS_FRAG_HI)
			seen_frag[12:8] = item.frame_byte[4:0];
		else if (at == POS_FRAG_LO)
			seen_frag[7:0] = item.frame_byte;
		else if (at == POS_PROTO)
			seen_proto = item.frame_byte;
		else if (at >= POS_DEST_FST && at <= POS_DEST_LST)
			seen_dest = {seen_dest[23:0], item.frame_byte};
		// The source port sits right after the IP header, wherever IHL puts it.
		if (seen_ihl >= MIN_IHL) begin
			l4 = int'(ETH_HDR_LEN) + 4 * int'(seen_ihl);
			if (at == l4)
				seen_sport[15:8] = item.frame_byte;
			else if (at == l4 + 1)
				seen_sport[7:0] = item.frame_byte;
		end
		// The position sticks at its top, so long frames count as 128 bytes.
		if (at_pos != POS_MAX)
			at_pos++;
		last = item.frame_end;
		v = '0;
		if (last) begin
			v = judge_frame(at + 1);
			at_pos = '0;
			seen_etype = '0;
			seen_ihl = '0;
			seen_frag = '0;
			seen_proto = '0;
			seen_dest = '0;
			seen_sport = '0;
		end
	endfunction

	// Follows a register write; unknown indexes are ignored and the port register
	// keeps only its low sixteen bits.
	function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
		case (idx)
			CFG_FIRST_BASE:  net_base[0] = data;
			CFG_FIRST_MASK:  net_mask[0] = data;
			CFG_SECOND_BASE: net_base[1] = data;
			CFG_SECOND_MASK: net_mask[1] = data;
			CFG_THIRD_BASE:  net_base[2] = data;
			CFG_THIRD_MASK:  net_mask[2] = data;
			CFG_EXEMPT_PORT: exempt_port = data[15:0];
			default: ;
		endcase
	endfunction

	// Everything is sampled at the rising edge, before the block's own registers
	// move, while the testbench only changes inputs at the falling edge.
	always @(posedge clk) begin : watch
		logic     last;
		verdict_t guess;
		if (arst_n) begin
			if (frame_valid && !frame_stall) begin
				filter_byte(frame, last, guess);
				if (last)
					pending_verdicts.push_back(pin_on ? pin_verdict : guess);
			end
			if (cfg_valid && cfg_ready)
				apply_reg(cfg_index, cfg_data);
			if (verdict_valid && !verdict_stall) begin
				if (pending_verdicts.size() == 0) begin
					flag_mismatch("verdict with none pending (drop, reason)", 0,
						int'(verdict));
				end else begin
					guess = pending_verdicts.pop_front();
					if (verdict.drop !== guess.drop)
						flag_mismatch("drop", int'(guess.drop), int'(verdict.drop));
					if (verdict.reason !== guess.reason)
						flag_mismatch("reason", int'(guess.reason), int'(verdict.reason));
				end
			end
		end
	end

	// The watchdog: a hung block or a lost verdict ends the run here.
	always @(posedge clk) begin
		cycle++;
		if (cycle >= CYCLE_LIMIT) begin
			$display("** private_ipv4_packet_filter_unit: FAILED **");
			$finish;
		end
	end

	// The verdict receiver stalls on its own schedule: never, now and then, or in
	// long runs that back up the record queue and push back on the frame side.
	always @(negedge clk) begin
		case (stall_mode)
			STALL_NONE: verdict_stall = 1'b0;
			STALL_SPARSE: verdict_stall = ($urandom_range(0, 3) == 0);
			default: begin
				if (stall_run == 0) begin
					verdict_stall = ~verdict_stall;
					stall_run = verdict_stall ? $urandom_range(1, 15) : $urandom_range(1, 10);
				end else begin
					stall_run--;
				end
			end
		endcase
	end

	// Presents one byte and holds it until a transaction takes it. The sender works
	// in bursts; between bursts it may drop valid for a random gap.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = sender_gaps ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				frame_valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		frame_valid = 1'b1;
		frame.frame_byte = b;
		frame.frame_end = last;
		do @(posedge clk); while (frame_stall);
		@(negedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// The byte at position i of a described frame: a header field where one
	// lives, filler elsewhere.
	function automatic logic [7:0] byte_at(input frame_desc_t d, input int i);
		logic [7:0] b;
		int         l4;
		b = d.fill[8] ? 8'($urandom_range(0, 255)) : d.fill[7:0];
		l4 = int'(ETH_HDR_LEN) + 4 * int'(d.ver_ihl[3:0]);
		if (i == POS_ETYPE_HI)
			b = d.etype[15:8];
		else if (i == POS_ETYPE_LO)
			b = d.etype[7:0];
		else if (i == POS_IHL)
			b = d.ver_ihl;
		else if (i == POS_FRAG_HI)
			b = d.frag[15:8];
		else if (i == POS_FRAG_LO)
			b = d.frag[7:0];
		else if (i == POS_PROTO)
			b = d.proto;
		else if (i >= POS_DEST_FST && i <= POS_DEST_LST)
			b = d.dest[8 * (int'(POS_DEST_LST) - i) +: 8];
		else if (d.ver_ihl[3:0] >= MIN_IHL && i == l4)
			b = d.sport[15:8];
		else if (d.ver_ihl[3:0] >= MIN_IHL && i == l4 + 1)
			b = d.sport[7:0];
		return b;
	endfunction

	task automatic send_frame(input frame_desc_t d);
		pin_on = d.pinned;
		pin_verdict = d.want;
		for (int i = 0; i < int'(d.len); i++)
			send_byte(byte_at(d, i), i == int'(d.len) - 1);
		frames_sent++;
	endtask

	function automatic frame_desc_t row(input int len, input logic [15:0] etype,
			input logic [7:0] ver_ihl, input logic [15:0] frag, input logic [7:0] proto,
			input logic [31:0] dest, input logic [15:0] sport, input logic [8:0] fill,
			input int pinned, input int drop, input logic [2:0] reason);
		frame_desc_t d;
		d.len = len[7:0];
		d.etype = etype;
		d.ver_ihl = ver_ihl;
		d.frag = frag;
		d.proto = proto;
		d.dest = dest;
		d.sport = sport;
		d.fill = fill;
		d.pinned = (pinned != 0);
		d.want.drop = (drop != 0);
		d.want.reason = reason;
		return d;
	endfunction

	// A random frame. Most are well-formed IPv4 with random content, aimed at the
	// configured subnets and the exempt port often enough to reach every verdict;
	// the rest are tiny frames and loosely formed noise.
	task automatic send_random_frame();
		frame_desc_t d;
		int          kind;
		int          r;
		int          ihl;
		int          l4;
		int          s;
		d = '0;
		d.fill = FILL_RANDOM;
		kind = $urandom_range(0, 99);
		r = $urandom_range(0, 99);
		ihl = (r < 70) ? 5 : (r < 88) ? $urandom_range(6, 15) : $urandom_range(0, 4);
		d.ver_ihl = {($urandom_range(0, 9) != 0) ? 4'h4 : 4'($urandom_range(0, 15)),
			4'(ihl)};
		d.etype = ($urandom_range(0, 99) < 88) ? ETYPE_IPV4 : 16'($urandom_range(0, 65535));
		d.frag = ($urandom_range(0, 99) < 82) ? {3'($urandom_range(0, 7)), 13'd0} :
			16'($urandom_range(0, 65535));
		r = $urandom_range(0, 99);
		d.proto = (r < 30) ? PROTO_ICMP : (r < 70) ? PROTO_TCP : (r < 85) ? 8'd17 :
			8'($urandom_range(0, 255));
		s = $urandom_range(0, 3);
		if (s < 3)
			d.dest = (net_base[s] & net_mask[s]) | ($urandom & ~net_mask[s]);
		else
			d.dest = $urandom;
		d.sport = ($urandom_range(0, 99) < 45) ? exempt_port : 16'($urandom_range(0, 65535));
		l4 = (ihl >= 5) ? 14 + 4 * ihl : 34;
		r = $urandom_range(0, 99);
		if (r < 8)
			d.len = 8'($urandom_range(1, 33));
		else if (r < 22)
			d.len = 8'($urandom_range(l4 + 2, l4 + 5));
		else if (r < 94)
			d.len = 8'($urandom_range(l4 + 4, l4 + 14));
		else
			d.len = 8'($urandom_range(100, 160));
		if (kind < 10) begin
			// Noise: every field random, half of it still tagged as IPv4.
			d.etype = $urandom_range(0, 1) ? ETYPE_IPV4 : 16'($urandom_range(0, 65535));
			d.ver_ihl = 8'($urandom_range(0, 255));
			d.frag = 16'($urandom_range(0, 65535));
			d.dest = $urandom;
			d.len = 8'($urandom_range(1, 70));
		end else if (kind < 16) begin
			// Runs of tiny frames pile up verdicts faster than a stalled receiver drains them.
			d.len = 8'($urandom_range(1, 3));
		end
		send_frame(d);
	endtask

	task automatic run_random(input int n_bytes, input int n_frames);
		int first_byte;
		int first_frame;
		first_byte = bytes_sent;
		first_frame = frames_sent;
		while (bytes_sent - first_byte < n_bytes || frames_sent - first_frame < n_frames)
			send_random_frame();
		frame_valid = 1'b0;
	endtask

	// Waits until every owed verdict is in, then lets the pipeline drain.
	task automatic settle();
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// A write transaction; cfg_valid stays high for back-to-back writes.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic program_filter(input logic [31:0] b0, input logic [31:0] m0,
			input logic [31:0] b1, input logic [31:0] m1, input logic [31:0] b2,
			input logic [31:0] m2, input logic [31:0] port_word);
		write_reg(CFG_FIRST_BASE, b0);
		write_reg(CFG_FIRST_MASK, m0);
		write_reg(CFG_SECOND_BASE, b1);
		write_reg(CFG_SECOND_MASK, m1);
		write_reg(CFG_THIRD_BASE, b2);
		write_reg(CFG_THIRD_MASK, m2);
		write_reg(CFG_EXEMPT_PORT, port_word);
		cfg_valid = 1'b0;
	endtask

	initial begin : stimulus
		frame_desc_t directed_rows [$];
		logic [31:0] nb [3];
		logic [31:0] nm [3];
		int          plen;

		arst_n = 1'b0;
		frame_valid = 1'b0;
		frame = '0;
		verdict_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_FIRST_BASE;
		cfg_data = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames under the reset registers. Columns: length, ethertype,
		// version/IHL byte, flags/fragment word, protocol, destination, source port,
		// filler, then the typed verdict where there is one.
		directed_rows.push_back(row(1, 16'h0000, 8'h45, 16'h0000, PROTO_TCP, 32'h0A010203,
			16'd22, FILL_RANDOM, 1, 0, REASON_SHORT));
		directed_rows.push_back(row(13, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'h0A010203,
			16'd22, FILL_RANDOM, 1, 0, REASON_SHORT));
		directed_rows.push_back(row(14, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_ICMP, 32'h0A010203,
			16'd22, FILL_RANDOM, 1, 0, REASON_SHORT));
		// One byte short of a full destination address.
		directed_rows.push_back(row(33, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_ICMP, 32'h0A010203,
			16'd22, FILL_RANDOM, 1, 0, REASON_SHORT));
		directed_rows.push_back(row(34, 16'h86DD, 8'h45, 16'h0000, PROTO_ICMP, 32'h0A010203,
			16'd22, FILL_RANDOM, 1, 0, REASON_SHORT));
		directed_rows.push_back(row(34, ETYPE_IPV4, 8'h44, 16'h0000, PROTO_ICMP, 32'h0A010203,
			16'd22, FILL_RANDOM, 1, 0, REASON_BAD_HDR));
		directed_rows.push_back(row(34, ETYPE_IPV4, 8'h45, 16'h0001, PROTO_ICMP, 32'h0A010203,
			16'd22, FILL_RANDOM, 1, 0, REASON_BAD_HDR));
		directed_rows.push_back(row(34, ETYPE_IPV4, 8'h45, 16'h1F00, PROTO_ICMP, 32'h0A010203,
			16'd22, FILL_RANDOM, 1, 0, REASON_BAD_HDR));
		// Flag bits alone do not make a later fragment.
		directed_rows.push_back(row(34, ETYPE_IPV4, 8'h45, 16'hE000, PROTO_ICMP, 32'h0AFFFFFF,
			16'd22, FILL_RANDOM, 1, 1, REASON_ICMP));
		directed_rows.push_back(row(34, ETYPE_IPV4, 8'h45, 16'h4000, PROTO_ICMP, 32'h08080808,
			16'd22, FILL_RANDOM, 1, 0, REASON_PUBLIC));
		// TCP one byte short of four L4 bytes, then just long enough.
		directed_rows.push_back(row(37, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'hC0A80101,
			16'd22, FILL_RANDOM, 1, 0, REASON_SHORT));
		directed_rows.push_back(row(38, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'hC0A80101,
			16'd22, FILL_RANDOM, 1, 0, REASON_EXEMPT));
		directed_rows.push_back(row(38, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'hC0A80101,
			16'd23, FILL_RANDOM, 1, 1, REASON_PRIVATE));
		// The exempt port means nothing outside TCP.
		directed_rows.push_back(row(34, ETYPE_IPV4, 8'h45, 16'h0000, 8'd17, 32'hAC100001,
			16'd22, FILL_RANDOM, 1, 1, REASON_PRIVATE));
		// Just outside and just inside the 172.16/12 range.
		directed_rows.push_back(row(40, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'hAC200001,
			16'd9999, FILL_RANDOM, 1, 0, REASON_PUBLIC));
		directed_rows.push_back(row(38, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'hAC1FFFFF,
			16'h1600, FILL_RANDOM, 1, 1, REASON_PRIVATE));
		// The longest IP header moves the port to bytes 74 and 75.
		directed_rows.push_back(row(78, ETYPE_IPV4, 8'h4F, 16'h0000, PROTO_TCP, 32'h0A000000,
			16'd22, FILL_RANDOM, 1, 0, REASON_EXEMPT));
		directed_rows.push_back(row(77, ETYPE_IPV4, 8'h4F, 16'h0000, PROTO_TCP, 32'h0A000000,
			16'd22, FILL_RANDOM, 1, 0, REASON_SHORT));
		// Long frame: the byte count saturates well before the end.
		directed_rows.push_back(row(200, ETYPE_IPV4, 8'h45, 16'h0000, PROTO_TCP, 32'hC0A80000,
			16'd22, FILL_RANDOM, 1, 0, REASON_EXEMPT));
		// All-ones and all-zero frames.
		directed_rows.push_back(row(34, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 32'hFFFFFFFF,
			16'hFFFF, 9'h0FF, 1, 0, REASON_SHORT));
		directed_rows.push_back(row(34, 16'h0000, 8'h00, 16'h0000, 8'h00, 32'h00000000,
			16'h0000, 9'h000, 1, 0, REASON_SHORT));
		// The version nibble is not looked at.
		directed_rows.push_back(row(38, ETYPE_IPV4, 8'h05, 16'h0000, PROTO_TCP, 32'hC0A80000,
			16'h0000, FILL_RANDOM, 1, 1, REASON_PRIVATE));
		directed_rows.push_back(row(60, ETYPE_IPV4, 8'hF5, 16'h2000, PROTO_ICMP, 32'hFFFFFFFF,
			16'hFFFF, 9'h0FF, 1, 0, REASON_PUBLIC));
		// Left to the predictor: a saturated UDP frame and ICMP behind a long header.
		directed_rows.push_back(row(200, ETYPE_IPV4, 8'h45, 16'h0000, 8'd17, 32'hAC1A0A0A,
			16'd22, FILL_RANDOM, 0, 0, REASON_SHORT));
		directed_rows.push_back(row(34, ETYPE_IPV4, 8'h4F, 16'h0000, PROTO_ICMP, 32'h0A7F0001,
			16'd22, FILL_RANDOM, 0, 0, REASON_SHORT));

		sender_gaps = 1'b1;
		stall_mode = STALL_SPARSE;
		foreach (directed_rows[i])
			send_frame(directed_rows[i]);
		frame_valid = 1'b0;
		pin_on = 1'b0;

		// Random traffic under the reset registers.
		run_random(90, 2);
		settle();

		// One subnet with an empty mask takes in every address; the exempt port is at
		// its top and the data word carries ones above the port's width.
		program_filter(32'hFFFFFFFF, 32'h00000000, 32'h00000000, 32'hFFFFFFFF,
			$urandom, 32'hFFFFFFFF, 32'hFFFFFFFF);
		sender_gaps = 1'b0;
		stall_mode = STALL_NONE;
		run_random(90, 2);
		settle();

		// Host-exact subnets and port zero, with long stall runs.
		program_filter($urandom, 32'hFFFFFFFF, $urandom, 32'hFFFFFFFF, $urandom,
			32'hFFFFFFFF, 32'h00000000);
		sender_gaps = 1'b1;
		stall_mode = STALL_RUNS;
		run_random(90, 2);
		settle();

		// Random prefixes of any length, and a write to the spare index that must not
		// change anything.
		for (int k = 0; k < 3; k++) begin
			plen = $urandom_range(0, 32);
			nm[k] = 32'hFFFFFFFF << (32 - plen);
			nb[k] = $urandom;
		end
		program_filter(nb[0], nm[0], nb[1], nm[1], nb[2], nm[2], $urandom);
		write_reg(CFG_SPARE, $urandom);
		cfg_valid = 1'b0;
		sender_gaps = 1'b0;
		stall_mode = STALL_RUNS;
		run_random(90, 2);
		settle();

		// Arbitrary, non-contiguous masks.
		program_filter($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		sender_gaps = 1'b1;
		stall_mode = STALL_SPARSE;
		run_random(90, 2);

		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (mismatches == 0)
			$display("** private_ipv4_packet_filter_unit: PASSED **");
		else
			$display("** private_ipv4_packet_filter_unit: FAILED **");
		$finish;
	end

endmodule

>>> private_ipv4_packet_filter_unit.f
rtl/core/pifu_pkg.sv
rtl/core/pifu_parse.sv
rtl/core/pifu_queue.sv
rtl/core/pifu_verdict.sv
rtl/core/private_ipv4_packet_filter_unit.sv
rtl/core/pifu_checker.sv
verif/tb_private_ipv4_packet_filter_unit.sv
